/* sv/brt_pkg.sv */
`timescale 1ns / 1ps
// brt_pkg: shared constants, codes and word types of the reassembly tracker
// no dependencies

package brt_pkg;

	localparam int ENTRIES     = 16;
	localparam int SOURCE_BITS = 16;
	localparam int SRC_W       = (SOURCE_BITS < 16) ? SOURCE_BITS : 16;
	localparam int IDX_W       = $clog2(ENTRIES);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [31:0] MAX_TOTAL_RST    = 32'd16777216;
	localparam logic [7:0]  HIGHEST_KIND_RST = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_TOTAL    = 1'b0,
		REG_HIGHEST_KIND = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_PARTIAL   = 3'd0,
		ST_DONE      = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_BAD_KIND  = 3'd3,
		ST_TOO_LARGE = 3'd4,
		ST_RANGE     = 3'd5,
		ST_MISMATCH  = 3'd6,
		ST_FULL      = 3'd7
	} status_t;

	typedef struct packed {
		logic [15:0] source_id;
		logic [63:0] transfer_id;
		logic [7:0]  kind;
		logic [63:0] total;
		logic [63:0] offset;
		logic [31:0] length;
		logic        header_ok;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot;
		logic        write_enable;
		logic [7:0]  done_kind;
		logic [31:0] done_total;
		logic [32:0] received_bytes;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic check;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

endpackage

/* sv/brt_ctrl.sv */
`timescale 1ns / 1ps
// brt_ctrl: sequencing state machine and output valid of the tracker
// depends on brt_pkg

module brt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output brt_pkg::ctrl_cmd_t  cmd
);
	import brt_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		CHECK,
		LOOK,
		COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit_go;

	assign commit_go = (state_q == COMMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= CHECK;
				end
				CHECK:  state_q <= LOOK;
				LOOK:   state_q <= COMMIT;
				COMMIT: begin
					if (commit_go) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (commit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall    = (state_q != IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = (state_q == IDLE) && in_valid;
	assign cmd.check   = (state_q == CHECK);
	assign cmd.lookup  = (state_q == LOOK);
	assign cmd.commit  = commit_go;

endmodule

/* sv/brt_dp.sv */
`timescale 1ns / 1ps
// brt_dp: config registers, slot table, checks, lookup and result register
// depends on brt_pkg

module brt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  brt_pkg::ctrl_cmd_t              cmd,
	input  brt_pkg::in_word_t               in_word,
	input  logic                            cfg_write,
	input  logic [brt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output brt_pkg::out_word_t              out_word
);
	import brt_pkg::*;

	// config
	logic [31:0] max_total_q;
	logic [7:0]  highest_kind_q;

	// slot table
	logic [ENTRIES-1:0] valid_q;
	logic [SRC_W-1:0]   src_q  [ENTRIES];
	logic [63:0]        xfer_q [ENTRIES];
	logic [7:0]         kind_q [ENTRIES];
	logic [31:0]        size_q [ENTRIES];
	logic [32:0]        recv_q [ENTRIES];

	in_word_t  item_q;
	out_word_t out_q;

	// check stage
	logic               malformed_s1, bad_kind_s1, too_large_s1, off_gt_s1;
	logic [31:0]        diff_s1;
	logic [ENTRIES-1:0] match_s1, free_s1;

	// lookup stage
	logic               early_s2;
	status_t            early_code_s2;
	logic               hit_s2, free_any_s2;
	logic [IDX_W-1:0]   hit_idx_s2, free_idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q    <= MAX_TOTAL_RST;
			highest_kind_q <= HIGHEST_KIND_RST;
		end else if (cfg_write) begin
			if (cfg_index == REG_MAX_TOTAL) begin
				max_total_q <= cfg_data[31:0];
			end else if (cfg_index == REG_HIGHEST_KIND) begin
				highest_kind_q <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_word;
	end

	// header checks and parallel tag compare
	logic [ENTRIES-1:0] match_c, free_c;
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_c[i] = valid_q[i] && (src_q[i] == item_q.source_id[SRC_W-1:0])
				&& (xfer_q[i] == item_q.transfer_id);
			free_c[i]  = !valid_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			malformed_s1 <= !item_q.header_ok;
			bad_kind_s1  <= item_q.kind > highest_kind_q;
			too_large_s1 <= (|item_q.total[63:32]) || (item_q.total[31:0] > max_total_q);
			off_gt_s1    <= item_q.offset > item_q.total;
			diff_s1      <= item_q.total[31:0] - item_q.offset[31:0];
			match_s1     <= match_c;
			free_s1      <= free_c;
		end
	end

	// lowest set bit of match and free vectors
	logic             hit_c, free_any_c;
	logic [IDX_W-1:0] hit_idx_c, free_idx_c;
	always_comb begin
		hit_c      = 1'b0;
		free_any_c = 1'b0;
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit_c     = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
			if (free_s1[i]) begin
				free_any_c = 1'b1;
				free_idx_c = IDX_W'(i);
			end
		end
	end

	logic    early_c;
	status_t early_code_c;
	always_comb begin
		early_c      = 1'b1;
		early_code_c = ST_MALFORMED;
		priority if (malformed_s1) begin
			early_code_c = ST_MALFORMED;
		end else if (bad_kind_s1) begin
			early_code_c = ST_BAD_KIND;
		end else if (too_large_s1) begin
			early_code_c = ST_TOO_LARGE;
		end else if (off_gt_s1 || (item_q.length > diff_s1)) begin
			early_code_c = ST_RANGE;
		end else begin
			early_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			early_s2      <= early_c;
			early_code_s2 <= early_code_c;
			hit_s2        <= hit_c;
			free_any_s2   <= free_any_c;
			hit_idx_s2    <= hit_idx_c;
			free_idx_s2   <= free_idx_c;
		end
	end

	// slot update
	logic [IDX_W-1:0] sel;
	logic             is_new, mismatch, complete;
	logic [7:0]       e_kind;
	logic [31:0]      e_size;
	logic [32:0]      e_recv, sum;
	logic [3:0]       slot_c;
	out_word_t        res_c;
	logic             keep_c;

	always_comb begin
		sel      = hit_s2 ? hit_idx_s2 : free_idx_s2;
		is_new   = !hit_s2;
		e_kind   = is_new ? item_q.kind : kind_q[sel];
		e_size   = is_new ? item_q.total[31:0] : size_q[sel];
		e_recv   = is_new ? 33'd0 : recv_q[sel];
		mismatch = !is_new && ((size_q[sel] != item_q.total[31:0])
			|| (kind_q[sel] != item_q.kind));
		sum      = e_recv + {1'b0, item_q.length};
		complete = sum >= {1'b0, e_size};
		slot_c   = 4'({4'b0, sel});
		keep_c   = 1'b0;
		res_c    = '0;
		priority if (early_s2) begin
			res_c.status = early_code_s2;
		end else if (!hit_s2 && !free_any_s2) begin
			res_c.status = ST_FULL;
		end else if (mismatch) begin
			res_c.status = ST_MISMATCH;
			res_c.slot   = slot_c;
		end else if (complete) begin
			res_c.status         = ST_DONE;
			res_c.slot           = slot_c;
			res_c.write_enable   = |item_q.length;
			res_c.done_kind      = e_kind;
			res_c.done_total     = e_size;
			res_c.received_bytes = sum;
		end else begin
			res_c.status         = ST_PARTIAL;
			res_c.slot           = slot_c;
			res_c.write_enable   = |item_q.length;
			res_c.received_bytes = sum;
			keep_c               = 1'b1;
		end
	end

	logic do_update;
	assign do_update = cmd.commit && !early_s2 && (hit_s2 || free_any_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_update) begin
			valid_q[sel] <= keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (do_update && keep_c) begin
			src_q[sel]  <= item_q.source_id[SRC_W-1:0];
			xfer_q[sel] <= item_q.transfer_id;
			kind_q[sel] <= e_kind;
			size_q[sel] <= e_size;
			recv_q[sel] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) out_q <= res_c;
	end

	assign out_word = out_q;

endmodule

/* sv/bulk_reassembly_tracker.sv */
`timescale 1ns / 1ps
// bulk_reassembly_tracker: piece header checks and slot tracking, top level
// an accepted word passes the check, lookup and commit states before output valid rises
// commit waits while the output register holds a stalled word; in_stall holds off new input until commit
// the output register holds a finished word while the next input is accepted
// reset clears all slot valid bits and loads the default register values at once
// depends on brt_pkg, brt_ctrl, brt_dp

module bulk_reassembly_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  brt_pkg::in_word_t               in_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output brt_pkg::out_word_t              out_word,
	input  logic                            cfg_write,
	input  logic [brt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import brt_pkg::*;

	ctrl_cmd_t cmd;

	brt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	brt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_word   (in_word),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_word  (out_word)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a word is in flight");

	a_out_rise_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 4))
		else $error("output word without matching input four cycles earlier");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_word.status == ST_DONE))
			|-> (out_word.received_bytes >= {1'b0, out_word.done_total}))
		else $error("completed transfer with count below total");

endmodule
